// ----- rtl/core/uart_frame_receiver_assert.svh -----
// Assertion macros for the UART frame receiver.
// Depends on clk and arst_n being visible where a macro is used.
`ifndef UART_FRAME_RECEIVER_ASSERT_SVH
`define UART_FRAME_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS

`define UFR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ufr assertion failed");

`define UFR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ufr assertion failed");

`else

`define UFR_ASSERT_NOW(label, ante, cons)

`define UFR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- rtl/core/ufr_pkg.sv -----
// Shared types and constants for the UART frame receiver.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ufr_pkg;

	localparam int DEPTH  = 512;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int LEN_W  = 10;
	localparam int IDX_W  = 9;
	localparam int REG_W  = 8;

	localparam logic [1:0] ACT_BYTE    = 2'd0;
	localparam logic [1:0] ACT_TICK    = 2'd1;
	localparam logic [1:0] ACT_READ    = 2'd2;
	localparam logic [1:0] ACT_RELEASE = 2'd3;

	localparam logic [1:0] CFG_TIMEOUT = 2'd0;
	localparam logic [1:0] CFG_START   = 2'd1;
	localparam logic [1:0] CFG_END1    = 2'd2;
	localparam logic [1:0] CFG_END2    = 2'd3;

	localparam logic [REG_W-1:0] RST_TIMEOUT = 8'd30;
	localparam logic [REG_W-1:0] RST_START   = 8'd42;
	localparam logic [REG_W-1:0] RST_END1    = 8'd13;
	localparam logic [REG_W-1:0] RST_END2    = 8'd10;

	typedef struct packed {
		logic [1:0]       action;
		logic [7:0]       rx_byte;
		logic             link_on;
		logic [IDX_W-1:0] read_index;
	} item_t;

	typedef struct packed {
		logic             frame_ready;
		logic [LEN_W-1:0] frame_length;
		logic [7:0]       read_data;
		logic             timed_out;
		logic             dropped;
		logic             released;
	} result_t;

endpackage

`default_nettype wire

// ----- rtl/core/ufr_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ufr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/uart_frame_receiver.sv -----
// UART frame receiver: each accepted word passes stage s1, then the result register.
// Throughput one word per cycle while not stalled; the single-port frame store takes
// one byte write or read per cycle; idle timer, fill count and last byte are flops.
// Asynchronous active-low reset clears control state and loads the register defaults;
// the frame store is not cleared, as reads are masked beyond the filled length.
// Depends on ufr_pkg, ufr_ram and uart_frame_receiver_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

module uart_frame_receiver (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [1:0]              cfg_index,
	input  wire logic [ufr_pkg::REG_W-1:0] cfg_data,
	input  wire logic                    item_valid,
	output logic                         item_stall,
	input  wire ufr_pkg::item_t          item,
	output logic                         result_valid,
	input  wire logic                    result_stall,
	output ufr_pkg::result_t             result
);

	import ufr_pkg::*;

	`include "uart_frame_receiver_assert.svh"

	logic [REG_W-1:0] timeout_q, start_q, end1_q, end2_q;
	logic [CNT_W-1:0] fill_q, fill_d;
	logic [REG_W-1:0] timer_q, timer_d, timer_dec;
	logic             done_q, done_d;
	logic [7:0]       prev_q, prev_d;

	logic             acc, s1_adv;
	logic             tout, drop, rel, ram_we, ram_re, rd_ok;
	logic [CNT_W:0]   filled_len;
	logic [ADDR_W-1:0] ram_addr;
	logic [7:0]       ram_rdata;

	logic             valid_s1, rd_s1;
	result_t          res_s1, res_d, res_out;

	assign s1_adv     = !result_valid || !result_stall;
	assign item_stall = valid_s1 && !s1_adv;
	assign acc        = item_valid && !item_stall;
	assign filled_len = {1'b0, fill_q} + (CNT_W + 1)'(done_q);
	assign timer_dec  = timer_q - 8'd1;

	always_comb begin
		fill_d   = fill_q;
		timer_d  = timer_q;
		done_d   = done_q;
		prev_d   = prev_q;
		tout     = 1'b0;
		drop     = 1'b0;
		rel      = 1'b0;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		rd_ok    = 1'b0;
		ram_addr = fill_q[ADDR_W-1:0];
		case (item.action)
			ACT_BYTE: begin
				if (item.link_on && !(fill_q == '0 && item.rx_byte != start_q)) begin
					if (done_q || fill_q >= CNT_W'(DEPTH)) begin
						drop = 1'b1;
					end else begin
						ram_we = acc;
						if (fill_q != '0 && item.rx_byte == end2_q && prev_q == end1_q) begin
							done_d = 1'b1;
						end else begin
							fill_d  = fill_q + CNT_W'(1);
							timer_d = timeout_q;
							prev_d  = item.rx_byte;
						end
					end
				end
			end
			ACT_TICK: begin
				if (fill_q == '0) begin
					timer_d = '0;
				end else if (!done_q && timer_q != '0) begin
					timer_d = timer_dec;
					if (timer_dec == '0) begin
						fill_d = '0;
						done_d = 1'b0;
						tout   = 1'b1;
					end
				end
			end
			ACT_READ: begin
				ram_addr = ADDR_W'(item.read_index);
				ram_re   = acc;
				rd_ok    = (CNT_W + 1)'(item.read_index) < filled_len &&
					(CNT_W + 1)'(item.read_index) < (CNT_W + 1)'(DEPTH);
			end
			ACT_RELEASE: begin
				if (done_q) begin
					fill_d  = '0;
					timer_d = '0;
					done_d  = 1'b0;
					rel     = 1'b1;
				end else if (fill_q >= CNT_W'(DEPTH)) begin
					fill_d  = '0;
					timer_d = '0;
					drop    = 1'b1;
				end
			end
			default: begin
				fill_d = fill_q;
			end
		endcase
	end

	always_comb begin
		res_d              = '0;
		res_d.frame_ready  = done_d;
		res_d.frame_length = done_d ? LEN_W'(fill_d) + LEN_W'(1) : '0;
		res_d.timed_out    = tout;
		res_d.dropped      = drop;
		res_d.released     = rel;
	end

	always_comb begin
		res_out           = res_s1;
		res_out.read_data = rd_s1 ? ram_rdata : 8'd0;
	end

	ufr_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(item.rx_byte),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= RST_TIMEOUT;
			start_q   <= RST_START;
			end1_q    <= RST_END1;
			end2_q    <= RST_END2;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TIMEOUT: timeout_q <= cfg_data;
				CFG_START:   start_q   <= cfg_data;
				CFG_END1:    end1_q    <= cfg_data;
				CFG_END2:    end2_q    <= cfg_data;
				default:     timeout_q <= timeout_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			timer_q <= '0;
			done_q  <= 1'b0;
		end else if (acc) begin
			fill_q  <= fill_d;
			timer_q <= timer_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			prev_q <= prev_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (!item_stall) begin
				valid_s1 <= acc;
			end
			if (s1_adv) begin
				result_valid <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall) begin
			res_s1 <= res_d;
			rd_s1  <= rd_ok;
		end
		if (s1_adv) begin
			result <= res_out;
		end
	end

	`UFR_ASSERT_NOW(a_done_below_depth, done_q, fill_q < CNT_W'(DEPTH))
	`UFR_ASSERT_NEXT(a_s1_held, valid_s1 && !s1_adv, valid_s1 && $stable(res_s1))
	`UFR_ASSERT_NOW(a_timeout_empties, result_valid && result.timed_out,
		!result.frame_ready && result.frame_length == '0)

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Testbench for uart_frame_receiver: random bursts of bytes, ticks, reads and releases
// are checked word by word against a cycle-free model of the frame store.
// Depends on ufr_pkg and the uart_frame_receiver RTL.
`timescale 1ns / 1ps

module tb;
	import ufr_pkg::*;

	class frame_scoreboard;
		logic [7:0]       store [DEPTH];
		int               fill;
		logic [7:0]       timer;
		bit               done;
		int               written_top;
		logic [REG_W-1:0] timeout_ticks;
		logic [REG_W-1:0] start_char;
		logic [REG_W-1:0] end1_char;
		logic [REG_W-1:0] end2_char;
		result_t          due [$];
		int               failures;

		function new();
			foreach (store[i]) store[i] = '0;
			fill = 0;
			timer = '0;
			done = 1'b0;
			written_top = 0;
			failures = 0;
			timeout_ticks = RST_TIMEOUT;
			start_char = RST_START;
			end1_char = RST_END1;
			end2_char = RST_END2;
		endfunction

		function void set_reg(input logic [1:0] idx, input logic [REG_W-1:0] v);
			case (idx)
				CFG_TIMEOUT: timeout_ticks = v;
				CFG_START:   start_char = v;
				CFG_END1:    end1_char = v;
				CFG_END2:    end2_char = v;
				default:     ;
			endcase
		endfunction

		function void empty_store();
			fill = 0;
			timer = '0;
			done = 1'b0;
		endfunction

		function void note_word(input item_t w);
			result_t r;
			int      len;
			r = '0;
			case (w.action)
				ACT_BYTE: begin
					if (w.link_on && !(fill == 0 && w.rx_byte != start_char)) begin
						if (done || fill >= DEPTH) begin
							r.dropped = 1'b1;
						end else begin
							store[fill] = w.rx_byte;
							if (fill >= written_top) written_top = fill + 1;
							if (fill != 0 && w.rx_byte == end2_char && store[fill - 1] == end1_char) begin
								done = 1'b1;
							end else begin
								fill++;
								timer = timeout_ticks;
							end
						end
					end
				end
				ACT_TICK: begin
					if (fill == 0) begin
						timer = '0;
					end else if (!done && timer != 0) begin
						timer--;
						if (timer == 0) begin
							empty_store();
							r.timed_out = 1'b1;
						end
					end
				end
				ACT_READ: begin
					len = done ? fill + 1 : fill;
					if (int'(w.read_index) < len) r.read_data = store[w.read_index];
				end
				default: begin
					if (done) begin
						empty_store();
						r.released = 1'b1;
					end else if (fill >= DEPTH) begin
						empty_store();
						r.dropped = 1'b1;
					end
				end
			endcase
			r.frame_ready = done;
			r.frame_length = done ? LEN_W'(fill + 1) : '0;
			due.push_back(r);
		endfunction

		function void check_status(input result_t got);
			result_t want;
			if (due.size() == 0) begin
				failures++;
				if (failures <= 10) $display("unexpected status word %h", got);
				return;
			end
			want = due.pop_front();
			if (got.frame_ready !== want.frame_ready || got.frame_length !== want.frame_length ||
					got.read_data !== want.read_data || got.timed_out !== want.timed_out ||
					got.dropped !== want.dropped || got.released !== want.released) begin
				failures++;
				if (failures <= 10) begin
					$display("status mismatch: want rdy=%0b len=%0d data=%h tout=%0b drop=%0b rel=%0b",
						want.frame_ready, want.frame_length, want.read_data,
						want.timed_out, want.dropped, want.released);
					$display("                 got  rdy=%0b len=%0d data=%h tout=%0b drop=%0b rel=%0b",
						got.frame_ready, got.frame_length, got.read_data,
						got.timed_out, got.dropped, got.released);
				end
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [1:0]       cfg_index = '0;
	logic [REG_W-1:0] cfg_data = '0;
	logic             item_valid = 1'b0;
	logic             item_stall;
	item_t            item = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	result_t          result;

	frame_scoreboard  sb;
	item_t            words_to_send [$];
	int               words_offered = 0;
	int               hold_requests = 0;

	uart_frame_receiver DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #6 clk = ~clk;

	initial begin : watchdog
		#6_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : sender
		int burst_left;
		int gap_left;
		bit fire;
		bit nv;
		burst_left = 1;
		gap_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			fire = item_valid && !item_stall;
			if (fire) sb.note_word(item);
			if (!item_valid || fire) begin
				nv = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (words_to_send.size() != 0) begin
					nv = 1'b1;
					item <= words_to_send.pop_front();
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
				item_valid <= nv;
			end
		end
	end

	initial begin : receiver
		int cyc;
		int hold_left;
		int seen;
		bit ns;
		cyc = 0;
		hold_left = 0;
		seen = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall) sb.check_status(result);
			if (seen != hold_requests) begin
				seen = hold_requests;
				hold_left = 80;
			end
			cyc++;
			if (hold_left > 0) begin
				ns = 1'b1;
				hold_left--;
			end else begin
				case ((cyc / 64) % 4)
					0:       ns = 1'b0;
					1:       ns = ($urandom_range(0, 3) == 0);
					2:       ns = ($urandom_range(0, 1) == 1);
					default: ns = (cyc % 11) < 4;
				endcase
			end
			result_stall <= ns;
		end
	end

	function automatic item_t word_of(input logic [1:0] act, input logic [7:0] b,
			input logic lk, input logic [IDX_W-1:0] idx);
		item_t w;
		w.action = act;
		w.rx_byte = b;
		w.link_on = lk;
		w.read_index = idx;
		return w;
	endfunction

	function automatic logic [7:0] byte_avoiding(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] v;
		do v = 8'($urandom); while (v == a || v == b);
		return v;
	endfunction

	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 5))
			0:       return 8'd0;
			1:       return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic offer(input item_t w);
		while (words_to_send.size() >= 4) @(negedge clk);
		words_to_send.push_back(w);
		words_offered++;
	endtask

	task automatic offer_tick();
		offer(word_of(ACT_TICK, 8'($urandom), 1'($urandom), IDX_W'($urandom)));
	endtask

	task automatic offer_release();
		offer(word_of(ACT_RELEASE, 8'($urandom), 1'($urandom), IDX_W'($urandom)));
	endtask

	task automatic offer_byte(input logic [7:0] b);
		offer(word_of(ACT_BYTE, b, 1'b1, IDX_W'($urandom)));
	endtask

	// read only positions that have been written at some point
	task automatic read_some(input int n);
		repeat (n) begin
			if (sb.written_top > 0)
				offer(word_of(ACT_READ, 8'($urandom), 1'($urandom),
					IDX_W'($urandom_range(0, sb.written_top - 1))));
		end
	endtask

	task automatic drain();
		while (words_to_send.size() != 0 || item_valid || sb.due.size() != 0) @(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [REG_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, v);
	endtask

	// terminate whatever is held and release it, or drop an over-full store
	task automatic flush_store();
		if (sb.fill != 0 || sb.done) begin
			offer_byte(sb.end1_char);
			offer_byte(sb.end2_char);
			offer_release();
			offer_release();
		end
	endtask

	task automatic new_phase(input logic [7:0] t, input logic [7:0] s,
			input logic [7:0] e1, input logic [7:0] e2);
		drain();
		write_reg(CFG_TIMEOUT, t);
		write_reg(CFG_START, s);
		write_reg(CFG_END1, e1);
		write_reg(CFG_END2, e2);
		flush_store();
	endtask

	task automatic long_frame();
		int k;
		new_phase(8'd0, 8'd0, 8'd255, 8'd0);
		offer_byte(8'd0);
		for (k = 1; k < 64; k++) begin
			if ($urandom_range(0, 15) == 0) offer_tick();
			offer_byte(byte_avoiding(8'd255, 8'd0));
		end
		offer_byte(8'd255);
		offer_byte(8'd0);
		offer_byte(8'($urandom));
		offer_tick();
		read_some(12);
		offer(word_of(ACT_READ, 8'($urandom), 1'($urandom), IDX_W'(DEPTH - 1)));
		offer_release();
		read_some(4);
	endtask

	task automatic overfill();
		int k;
		new_phase(8'd255, 8'd255, 8'd0, 8'd1);
		offer_byte(8'd255);
		for (k = 1; k < DEPTH; k++) offer_byte(byte_avoiding(8'd0, 8'd1));
		repeat (3) offer_byte(8'($urandom));
		repeat (2) offer_tick();
		read_some(6);
		offer_release();
		read_some(4);
	endtask

	task automatic random_phase(input int words, input bit hold);
		logic [7:0] t;
		logic [7:0] s;
		logic [7:0] e1;
		logic [7:0] e2;
		logic [1:0] act;
		int         target;
		int         n;
		case ($urandom_range(0, 6))
			0:       t = 8'd0;
			1:       t = 8'd1;
			2:       t = 8'd255;
			default: t = 8'($urandom_range(1, 6));
		endcase
		s = pick_char();
		e1 = pick_char();
		e2 = pick_char();
		if ($urandom_range(0, 5) == 0) e2 = s;
		if ($urandom_range(0, 5) == 0) e2 = e1;
		new_phase(t, s, e1, e2);
		if (hold) hold_requests++;
		target = words_offered + words;
		while (words_offered < target) begin
			if ($urandom_range(0, 3) != 0) begin
				offer_byte(s);
				n = $urandom_range(0, 10);
				repeat (n) begin
					if ($urandom_range(0, 4) == 0) offer_tick();
					if ($urandom_range(0, 7) == 0)
						repeat ($urandom_range(1, 8)) offer_tick();
					offer(word_of(ACT_BYTE, ($urandom_range(0, 5) == 0) ? e1 : 8'($urandom),
						$urandom_range(0, 15) != 0, IDX_W'($urandom)));
				end
				if ($urandom_range(0, 5) != 0) begin
					offer_byte(e1);
					offer_byte(e2);
				end
				repeat ($urandom_range(0, 2)) offer_tick();
				read_some($urandom_range(0, 3));
				if ($urandom_range(0, 4) != 0) offer_release();
				if ($urandom_range(0, 9) == 0) drain();
			end else begin
				repeat ($urandom_range(1, 6)) begin
					act = 2'($urandom);
					if (act == ACT_READ) begin
						if (sb.written_top > 0) read_some(1);
						else offer_tick();
					end else begin
						offer(word_of(act, ($urandom_range(0, 2) == 0) ? s : 8'($urandom),
							1'($urandom), IDX_W'($urandom)));
					end
				end
			end
		end
	endtask

	initial begin : stimulus
		int p;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		offer(word_of(ACT_BYTE, 8'd7, 1'b1, 9'd0));
		offer(word_of(ACT_BYTE, RST_START, 1'b0, 9'd0));
		offer(word_of(ACT_TICK, 8'd0, 1'b0, 9'd0));
		offer(word_of(ACT_RELEASE, 8'd0, 1'b0, 9'd0));
		offer(word_of(ACT_BYTE, RST_START, 1'b1, 9'h1FF));
		offer_byte(8'h00);
		offer_byte(8'hFF);
		offer_byte(RST_END1);
		offer_byte(RST_END2);
		offer_byte(8'h55);
		offer(word_of(ACT_TICK, 8'hFF, 1'b1, 9'h1FF));
		offer(word_of(ACT_READ, 8'd0, 1'b0, 9'd0));
		offer(word_of(ACT_READ, 8'd0, 1'b0, 9'd4));
		offer(word_of(ACT_RELEASE, 8'hFF, 1'b1, 9'h1FF));
		offer(word_of(ACT_READ, 8'd0, 1'b0, 9'd2));

		new_phase(8'd1, 8'd42, 8'd13, 8'd10);
		offer_byte(8'd42);
		offer_tick();
		offer_tick();
		offer_byte(8'd42);
		offer_byte(8'd10);
		offer_tick();

		long_frame();
		overfill();
		for (p = 0; p < 6; p++) random_phase(40, p == 1 || p == 4);

		drain();
		if (sb.failures == 0 && sb.due.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
